// ===== src/mavv_pkg.sv =====
// Shared types and constants for the moving average and variation filter.
package mavv_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SHIFT_RD,
		ST_SHIFT,
		ST_HEAD,
		ST_SUM,
		ST_DRAIN,
		ST_MUL,
		ST_CHECK,
		ST_DIV,
		ST_SQRT,
		ST_FINISH
	} mavv_state_t;

	typedef logic [1:0] mavv_mode_t;

	localparam mavv_mode_t MODE_VARIATION = 2'd0;
	localparam mavv_mode_t MODE_LONG_MEAN = 2'd1;
	localparam mavv_mode_t MODE_SHORT_MEAN = 2'd2;
	localparam mavv_mode_t MODE_UNUSED = 2'd3;

	localparam mavv_mode_t MODE_RESET = MODE_LONG_MEAN;

	// Register index taken from paddr[2]
	localparam logic REG_FILTER_MODE = 1'b0;

	localparam int SAMPLE_W = 16;
	localparam int RESULT_W = 24;
	localparam int DIV_STEPS = 32;
	localparam logic [RESULT_W-1:0] CV_MAX = 24'd65535;

	localparam int TUSER_IS_VARIATION = 0;
	localparam int TUSER_ZERO_MEAN = 1;

endpackage

// ===== src/moving_average_with_variation.sv =====
// Top level: windowed mean and coefficient of variation over a RAM-held sample window.
//
//  Channel  Direction  Signals                          Carries
//  s_*      in         s_tvalid s_tready s_tdata[15:0]  sample
//  m_*      out        m_tvalid m_tready m_tdata[23:0]  result_value
//                      m_tuser[1:0]                     result_is_variation, zero_mean
//  APB      in         psel penable pwrite paddr[2:0]   filter_mode at address 0
//
// One transaction at a time. A full window is first shifted through the RAM port, then
// n entries are read and summed. A mean then takes a divide; a coefficient of variation
// adds products, a divide and a square root.
// Reset clears the fill count and the output slot; the RAM needs no clearing.
// A new sample is taken while a finished result waits on m_tready.
module moving_average_with_variation
	import mavv_pkg::*;
#(
	parameter int WINDOW = 16,
	parameter int SHORT_WINDOW = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] sample
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [23:0] result_value
	output logic [1:0]  m_tuser,   // [0] result_is_variation, [1] zero_mean
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int DEPTH = (WINDOW > SHORT_WINDOW) ? WINDOW : SHORT_WINDOW;
	localparam int AW = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = SAMPLE_W + CNT_W;
	localparam int SQ_W = 2 * SAMPLE_W + CNT_W;
	localparam int DEN_W = 2 * SUM_W;
	localparam int D_W = SQ_W + CNT_W;
	localparam int LONG_TOP = WINDOW - 1;
	localparam int SHORT_TOP = (SHORT_WINDOW < DEPTH) ? SHORT_WINDOW : SHORT_WINDOW - 1;

	mavv_state_t state_q, state_d;
	mavv_mode_t  mode_q, op_mode_q;

	logic [CNT_W-1:0]    fill_q, n_q, rcnt_q, win_len;
	logic                full_q, win_full, accept, cfg_write;
	logic [SAMPLE_W-1:0] sample_q;
	logic [AW-1:0]       rptr_q;

	logic                ram_we, ram_re;
	logic [AW-1:0]       ram_waddr, ram_raddr;
	logic [SAMPLE_W-1:0] ram_wdata, ram_rdata;

	logic                  rv_s1, v_s2;
	logic [SAMPLE_W-1:0]   d_s2;
	logic [2*SAMPLE_W-1:0] sq_s2;
	logic [SUM_W-1:0]      sum_q;
	logic [SQ_W-1:0]       sumsq_q;
	logic [DEN_W-1:0]      sqs_q;
	logic [D_W-1:0]        nsq_q, diff;
	logic                  sat;

	logic [DEN_W-1:0] rem_q, den_q, rem_nxt;
	logic [DEN_W:0]   trial_div;
	logic             div_ge;
	logic [31:0]      low_q, quo_q, quo_nxt;
	logic [4:0]       step_q;
	logic             is_cv_q;

	logic [31:0] x_q, res_q, bit_q;
	logic [32:0] trial_sq;
	logic        sq_take;

	logic [RESULT_W-1:0] res_val_q;
	logic                res_var_q, res_zm_q;
	logic                out_load, drain_done;

	assign pready = 1'b1;
	assign cfg_write = psel & penable & pwrite;
	assign prdata = (paddr[2] == REG_FILTER_MODE) ? {30'd0, mode_q} : 32'd0;

	assign accept = s_tvalid & s_tready;
	assign win_len = (mode_q == MODE_SHORT_MEAN) ? CNT_W'(SHORT_WINDOW) : CNT_W'(WINDOW);
	assign win_full = (fill_q >= win_len);
	assign drain_done = !rv_s1 && !v_s2;
	assign out_load = (state_q == ST_FINISH) && (!m_tvalid || m_tready);

	// Restoring divider step
	assign trial_div = {rem_q, low_q[31]};
	assign div_ge = (trial_div >= {1'b0, den_q});
	assign rem_nxt = div_ge ? DEN_W'(trial_div - {1'b0, den_q}) : trial_div[DEN_W-1:0];
	assign quo_nxt = {quo_q[30:0], div_ge};

	// Square root step
	assign trial_sq = {1'b0, res_q} + {1'b0, bit_q};
	assign sq_take = ({1'b0, x_q} >= trial_sq);

	assign diff = nsq_q - D_W'(sqs_q);
	assign sat = ({8'd0, diff} >= (D_W + 8)'({sqs_q, 8'd0}));

	mavv_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(DEPTH)
	) u_window_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (mode_q == MODE_UNUSED) begin
						state_d = ST_FINISH;
					end else if (win_full) begin
						state_d = ST_SHIFT_RD;
					end else begin
						state_d = ST_SUM;
					end
				end
			end
			ST_SHIFT_RD: state_d = ST_SHIFT;
			ST_SHIFT: begin
				if (rptr_q == '0) begin
					state_d = ST_HEAD;
				end
			end
			ST_HEAD: state_d = ST_SUM;
			ST_SUM: begin
				if (rcnt_q == CNT_W'(n_q - 1'b1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (drain_done) begin
					if (op_mode_q != MODE_VARIATION) begin
						state_d = ST_DIV;
					end else if (!full_q || sum_q == '0) begin
						state_d = ST_FINISH;
					end else begin
						state_d = ST_MUL;
					end
				end
			end
			ST_MUL: state_d = ST_CHECK;
			ST_CHECK: state_d = sat ? ST_FINISH : ST_DIV;
			ST_DIV: begin
				if (step_q == 5'(DIV_STEPS - 1)) begin
					state_d = is_cv_q ? ST_SQRT : ST_FINISH;
				end
			end
			ST_SQRT: begin
				if (bit_q == '0) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		ram_we = 1'b0;
		ram_waddr = '0;
		ram_wdata = s_tdata;
		ram_re = 1'b0;
		ram_raddr = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				// Append while filling
				ram_we = accept && (mode_q != MODE_UNUSED) && !win_full;
				ram_waddr = fill_q[AW-1:0];
			end
			ST_SHIFT_RD: begin
				ram_re = 1'b1;
				ram_raddr = rptr_q;
			end
			ST_SHIFT: begin
				ram_we = 1'b1;
				ram_waddr = AW'(rptr_q + 1'b1);
				ram_wdata = ram_rdata;
				ram_re = (rptr_q != '0);
				ram_raddr = AW'(rptr_q - 1'b1);
			end
			ST_HEAD: begin
				ram_we = 1'b1;
				ram_waddr = '0;
				ram_wdata = sample_q;
			end
			ST_SUM: begin
				ram_re = 1'b1;
				ram_raddr = rcnt_q[AW-1:0];
			end
			ST_DRAIN, ST_MUL, ST_CHECK, ST_DIV, ST_SQRT, ST_FINISH: begin
				ram_we = 1'b0;
			end
			default: ram_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q <= MODE_RESET;
			fill_q <= '0;
			m_tvalid <= 1'b0;
			rv_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write && paddr[2] == REG_FILTER_MODE) begin
				mode_q <= mavv_mode_t'(pwdata[1:0]);
			end
			if (accept && mode_q != MODE_UNUSED && !win_full) begin
				fill_q <= CNT_W'(fill_q + 1'b1);
			end
			if (out_load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			rv_s1 <= (state_q == ST_SUM);
			v_s2 <= rv_s1;
		end
	end

	always_ff @(posedge clk) begin
		// Sum pipeline: RAM read, square, accumulate
		if (rv_s1) begin
			d_s2 <= ram_rdata;
			sq_s2 <= ram_rdata * ram_rdata;
		end
		if (v_s2) begin
			sum_q <= sum_q + SUM_W'(d_s2);
			sumsq_q <= sumsq_q + SQ_W'(sq_s2);
		end
		if (out_load) begin
			m_tdata <= res_val_q;
			m_tuser[TUSER_IS_VARIATION] <= res_var_q;
			m_tuser[TUSER_ZERO_MEAN] <= res_zm_q;
		end
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					sample_q <= s_tdata;
					op_mode_q <= mode_q;
					sum_q <= '0;
					sumsq_q <= '0;
					rcnt_q <= '0;
					res_val_q <= '0;
					res_var_q <= 1'b0;
					res_zm_q <= 1'b0;
					rptr_q <= (mode_q == MODE_SHORT_MEAN) ? AW'(SHORT_TOP - 1) : AW'(LONG_TOP - 1);
					full_q <= win_full;
					n_q <= win_full ? win_len : CNT_W'(fill_q + 1'b1);
				end
			end
			ST_SHIFT: begin
				if (rptr_q != '0) begin
					rptr_q <= AW'(rptr_q - 1'b1);
				end
			end
			ST_SUM: rcnt_q <= CNT_W'(rcnt_q + 1'b1);
			ST_DRAIN: begin
				if (drain_done) begin
					rem_q <= '0;
					low_q <= 32'({sum_q, 8'd0});
					den_q <= DEN_W'(n_q);
					quo_q <= '0;
					step_q <= '0;
					is_cv_q <= 1'b0;
					if (op_mode_q == MODE_VARIATION && full_q && sum_q == '0) begin
						res_val_q <= CV_MAX;
						res_var_q <= 1'b1;
						res_zm_q <= 1'b1;
					end
				end
			end
			ST_MUL: begin
				sqs_q <= sum_q * sum_q;
				nsq_q <= n_q * sumsq_q;
			end
			ST_CHECK: begin
				res_var_q <= 1'b1;
				if (sat) begin
					res_val_q <= CV_MAX;
				end
				rem_q <= DEN_W'(diff >> 8);
				low_q <= {diff[7:0], 24'd0};
				den_q <= sqs_q;
				quo_q <= '0;
				step_q <= '0;
				is_cv_q <= 1'b1;
			end
			ST_DIV: begin
				rem_q <= rem_nxt;
				low_q <= {low_q[30:0], 1'b0};
				quo_q <= quo_nxt;
				step_q <= 5'(step_q + 1'b1);
				x_q <= quo_nxt;
				res_q <= '0;
				bit_q <= 32'd1 << 30;
				if (!is_cv_q) begin
					res_val_q <= quo_nxt[RESULT_W-1:0];
				end
			end
			ST_SQRT: begin
				if (bit_q == '0) begin
					res_val_q <= {8'd0, res_q[15:0]};
				end else begin
					if (sq_take) begin
						x_q <= 32'(({1'b0, x_q}) - trial_sq);
						res_q <= (res_q >> 1) + bit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end
			end
			ST_SHIFT_RD, ST_HEAD, ST_FINISH: begin
				is_cv_q <= is_cv_q;
			end
			default: is_cv_q <= is_cv_q;
		endcase
	end

endmodule

// ===== src/mavv_ram.sv =====
// Generic simple dual-port RAM with registered read.
module mavv_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sim/moving_average_with_variation_test.sv =====
// Self-checking testbench for the moving average and variation filter.
`timescale 1ns / 1ps

module moving_average_with_variation_test
	import mavv_pkg::*;
();

	localparam int WIN = 16;
	localparam int SWIN = 5;

	typedef struct packed {
		logic [23:0] value;
		logic        is_var;
		logic        zmean;
	} filt_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	moving_average_with_variation #(.WINDOW(WIN), .SHORT_WINDOW(SWIN)) dut (.*);

	logic [15:0]  sample_queue[$];
	filt_result_t result_queue[$];
	int           fail_count;
	int           send_gap;
	int           recv_gap;

	// predictor state
	logic [15:0] win_mem[WIN];
	int          win_fill;
	mavv_mode_t  cur_mode;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [63:0] int_sqrt(logic [63:0] x);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [23:0] variation_q12(logic [63:0] sum, logic [63:0] sumsq, int n);
		logic [63:0] d;
		logic [63:0] den;
		logic [63:0] q;
		logic [63:0] r;
		d = n * sumsq - sum * sum;
		den = sum * sum;
		if (d >= (den << 8)) return CV_MAX;
		q = d / den;
		r = d % den;
		for (int k = 0; k < 24; k++) begin
			r = r << 1;
			q = q << 1;
			if (r >= den) begin
				r = r - den;
				q[0] = 1'b1;
			end
		end
		q = int_sqrt(q);
		return (q > 65535) ? CV_MAX : q[23:0];
	endfunction

	function automatic filt_result_t filter_sample(logic [15:0] s);
		filt_result_t res;
		logic [63:0]  sum;
		logic [63:0]  sumsq;
		int           len;
		int           n;
		bit           full;
		res = '0;
		sum = 0;
		sum = 0;
		sumsq = 0;
		if (cur_mode == MODE_UNUSED) return res;
		len = (cur_mode == MODE_SHORT_MEAN) ? SWIN : WIN;
		full = win_fill >= len;
		if (!full) begin
			win_mem[win_fill] = s;
			win_fill++;
			n = win_fill;
		end else begin
			// short window also moves its top entry one place up, before the rest shift
			if (cur_mode == MODE_SHORT_MEAN && SWIN < WIN) win_mem[SWIN] = win_mem[SWIN - 1];
			for (int i = len - 1; i > 0; i--) win_mem[i] = win_mem[i - 1];
			win_mem[0] = s;
			n = len;
		end
		for (int i = 0; i < n; i++) begin
			sum += win_mem[i];
			sumsq += 64'(win_mem[i]) * win_mem[i];
		end
		if (cur_mode != MODE_VARIATION) begin
			res.value = 24'((sum << 8) / n);
		end else if (full) begin
			res.is_var = 1'b1;
			if (sum == 0) begin
				res.zmean = 1'b1;
				res.value = CV_MAX;
			end else begin
				res.value = variation_q12(sum, sumsq, n);
			end
		end
		return res;
	endfunction

	task automatic report_mismatch(string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		fail_count++;
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			send_gap <= $urandom_range(0, 15);
		end else if (s_tvalid && !s_tready) begin
		end else if (send_gap > 0) begin
			s_tvalid <= 1'b0;
			send_gap <= send_gap - 1;
		end else if (sample_queue.size() > 0) begin
			s_tvalid <= 1'b1;
			s_tdata <= sample_queue[0];
			result_queue.push_back(filter_sample(sample_queue.pop_front()));
			send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_gap <= $urandom_range(0, 15);
		end else begin
			if (m_tvalid && m_tready) begin
				if (result_queue.size() == 0) begin
					report_mismatch("result with none expected");
				end else if (m_tdata !== result_queue[0].value
						|| m_tuser[TUSER_IS_VARIATION] !== result_queue[0].is_var
						|| m_tuser[TUSER_ZERO_MEAN] !== result_queue[0].zmean) begin
					report_mismatch($sformatf("got %h/%b want %h/%b%b", m_tdata, m_tuser,
						result_queue[0].value, result_queue[0].zmean,
						result_queue[0].is_var));
					void'(result_queue.pop_front());
				end else begin
					void'(result_queue.pop_front());
				end
				recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
				m_tready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic wait_drained();
		while (sample_queue.size() > 0 || s_tvalid || result_queue.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_mode(mavv_mode_t m);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= {REG_FILTER_MODE, 2'b00};
		pwdata <= 32'(m);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cur_mode = m;
	endtask

	task automatic queue_samples(int count, int kind);
		for (int i = 0; i < count; i++) begin
			case (kind)
				0: sample_queue.push_back(16'($urandom));
				1: sample_queue.push_back(16'($urandom_range(1000, 1100)));
				2: sample_queue.push_back(16'($urandom_range(0, 3)));
				default: sample_queue.push_back(16'($urandom_range(65500, 65535)));
			endcase
		end
	endtask

	initial begin
		mavv_mode_t mode_seq[$];
		fail_count = 0;
		win_fill = 0;
		cur_mode = MODE_RESET;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset mode, extremes, all zeros in variation mode, unused mode
		sample_queue.push_back(16'hFFFF);
		sample_queue.push_back(16'h0000);
		sample_queue.push_back(16'h5555);
		sample_queue.push_back(16'hAAAA);
		wait_drained();
		write_mode(MODE_UNUSED);
		sample_queue.push_back(16'h1234);
		wait_drained();
		write_mode(MODE_VARIATION);
		repeat (18) sample_queue.push_back(16'h0000);
		wait_drained();
		write_mode(MODE_SHORT_MEAN);
		sample_queue.push_back(16'hFFFF);
		wait_drained();

		// random phases: cycle through modes, extremes included; drain before each mode change
		mode_seq = {MODE_VARIATION, MODE_SHORT_MEAN, MODE_LONG_MEAN, MODE_VARIATION,
			MODE_UNUSED, MODE_SHORT_MEAN, MODE_VARIATION, MODE_LONG_MEAN};
		for (int p = 0; p < 40; p++) begin
			wait_drained();
			write_mode(mode_seq[p % mode_seq.size()]);
			queue_samples(50, $urandom_range(0, 3));
		end
		wait_drained();
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
src/mavv_pkg.sv
src/mavv_ram.sv
src/moving_average_with_variation.sv
sim/moving_average_with_variation_test.sv
